// ----- rtl/mlsq_pkg.sv -----
// Shared types, codes and default sizes of the multi-list stack/queue manager.
package mlsq_pkg;

   // Default sizes handed to the top level parameters
   localparam int LISTS_DEFAULT     = 16;
   localparam int NODES_DEFAULT     = 256;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed field widths of the channel words
   localparam int CMD_W    = 2;
   localparam int ID_W     = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_POP    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_EXISTS  = 3'd1,
      STAT_MISSING = 3'd2,
      STAT_EMPTY   = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_LOOK  = 2'd1,
      S_FETCH = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   list_id;
      logic              is_stack;
      logic [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data_out;
   } rsp_type;

   // Requests from the sequencer to the node allocator
   typedef struct packed {
      logic grab;
      logic drop;
   } pool_ctl_type;

endpackage

// ----- rtl/mlsq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mlsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mlsq_pool.sv -----
// Node allocator: recycled free chain and never-used region of the node pool.
module mlsq_pool #(
   parameter int NODES = mlsq_pkg::NODES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mlsq_pkg::pool_ctl_type     ctl,
   input  logic [$clog2(NODES)-1:0]   link_next,
   input  logic [$clog2(NODES)-1:0]   drop_node,
   output logic                       avail,
   output logic [$clog2(NODES)-1:0]   grab_node,
   output logic [$clog2(NODES)-1:0]   free_top
);

   localparam int NODE_AW = $clog2(NODES);
   localparam int CNT_W   = $clog2(NODES + 1);

   logic [NODE_AW-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0]   free_depth_ff, free_depth_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic               chain_busy;

   assign chain_busy = (free_depth_ff != '0);
   assign avail      = chain_busy || (fresh_ff != CNT_W'(NODES));
   assign grab_node  = chain_busy ? free_top_ff : fresh_ff[NODE_AW-1:0];
   assign free_top   = free_top_ff;

   // Pop the free chain first, then advance the fresh mark; push freed nodes
   always_comb begin
      free_top_in   = free_top_ff;
      free_depth_in = free_depth_ff;
      fresh_in      = fresh_ff;
      if (ctl.grab) begin
         if (chain_busy) begin
            free_top_in   = link_next;
            free_depth_in = free_depth_ff - CNT_W'(1);
         end else begin
            fresh_in = fresh_ff + CNT_W'(1);
         end
      end else if (ctl.drop) begin
         free_top_in   = drop_node;
         free_depth_in = free_depth_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff   <= '0;
         free_depth_ff <= '0;
         fresh_ff      <= '0;
      end else begin
         free_top_ff   <= free_top_in;
         free_depth_ff <= free_depth_in;
         fresh_ff      <= fresh_in;
      end
   end

endmodule

// ----- rtl/multi_list_stack_queue_manager.sv -----
// Top level: sequencer of the multi-list stack/queue manager over list and node memories.
//
// Usage:
//   Request channel (req_valid / req_stall / req_word) takes one command word:
//   create, push or pop on a list slot. Response channel (rsp_valid /
//   rsp_stall / rsp_word) returns exactly one word per command with a status
//   and, for a successful pop, the popped data.
//   Each command is looked up in S_LOOK and answered from there, but a pop
//   of a non-empty list goes on to S_FETCH first; the next command is taken
//   in the cycle after the answer is loaded, so commands do not overlap.
//   The sequence is set by the registered read of the list memory and,
//   for pop, by the dependent read of the node memory at the list head.
//   The response sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, a finished command holds in the
//   sequencer, with no state written, until the output register frees.
//   Synchronous reset closes every list slot and empties the node pool;
//   memory contents are not cleared and need no clearing pass.
module multi_list_stack_queue_manager #(
   parameter int LISTS     = mlsq_pkg::LISTS_DEFAULT,
   parameter int NODES     = mlsq_pkg::NODES_DEFAULT,
   parameter int WORD_BITS = mlsq_pkg::WORD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlsq_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlsq_pkg::rsp_type rsp_word
);

   localparam int LIST_AW = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int ID_WIDE = (LIST_AW > mlsq_pkg::ID_W) ? LIST_AW : mlsq_pkg::ID_W;
   localparam int NODE_AW = $clog2(NODES);
   localparam int CNT_W   = $clog2(NODES + 1);
   localparam int STORE_W = (WORD_BITS < mlsq_pkg::DATA_W) ? WORD_BITS : mlsq_pkg::DATA_W;
   localparam int ENTRY_W = 1 + CNT_W + 2 * NODE_AW;

   mlsq_pkg::state_type state_ff, state_in;
   mlsq_pkg::req_type   req_ff, req_in;
   mlsq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LISTS-1:0]    used_ff, used_in;

   logic                req_fire, out_free, rsp_load;
   logic [ID_WIDE-1:0]  id_acc_wide, id_cur_wide;
   logic [LIST_AW-1:0]  id_acc, id_cur;
   logic                id_ok, slot_used;

   // List memory ports and unpacked entry
   logic               list_we, list_re;
   logic [LIST_AW-1:0] list_ra;
   logic [ENTRY_W-1:0] list_wd, list_rd;
   logic               l_stack;
   logic [CNT_W-1:0]   l_count;
   logic [NODE_AW-1:0] l_tail, l_head;
   logic               n_stack;
   logic [CNT_W-1:0]   n_count;
   logic [NODE_AW-1:0] n_tail, n_head;

   // Node link and node word memory ports
   logic               link_we, link_re;
   logic [NODE_AW-1:0] link_wa, link_wd, link_ra, link_rd;
   logic               word_we, word_re;
   logic [NODE_AW-1:0] word_wa, word_ra;
   logic [STORE_W-1:0] word_wd, word_rd;

   // Allocator
   mlsq_pkg::pool_ctl_type pool_ctl;
   logic                   pool_avail;
   logic [NODE_AW-1:0]     grab_node, free_top;

   assign req_stall = (state_ff != mlsq_pkg::S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign id_acc_wide = ID_WIDE'(req_word.list_id);
   assign id_acc      = id_acc_wide[LIST_AW-1:0];
   assign id_cur_wide = ID_WIDE'(req_ff.list_id);
   assign id_cur      = id_cur_wide[LIST_AW-1:0];
   assign id_ok       = (32'(req_ff.list_id) < 32'(LISTS));
   assign slot_used   = id_ok && used_ff[id_cur];

   assign {l_stack, l_count, l_tail, l_head} = list_rd;
   assign list_wd = {n_stack, n_count, n_tail, n_head};

   mlsq_ram #(.WIDTH(ENTRY_W), .DEPTH(LISTS)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (id_cur),
      .wr_data (list_wd),
      .rd_en   (list_re),
      .rd_addr (list_ra),
      .rd_data (list_rd)
   );

   mlsq_ram #(.WIDTH(NODE_AW), .DEPTH(NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   mlsq_ram #(.WIDTH(STORE_W), .DEPTH(NODES)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (word_wa),
      .wr_data (word_wd),
      .rd_en   (word_re),
      .rd_addr (word_ra),
      .rd_data (word_rd)
   );

   mlsq_pool #(.NODES(NODES)) u_pool (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pool_ctl),
      .link_next (link_rd),
      .drop_node (l_head),
      .avail     (pool_avail),
      .grab_node (grab_node),
      .free_top  (free_top)
   );

   // Sequence one command: look up the list, then modify and write back
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      used_in       = used_ff;
      rsp_in        = rsp_ff;
      rsp_load      = 1'b0;
      list_we       = 1'b0;
      list_re       = 1'b0;
      list_ra       = id_acc;
      n_stack       = l_stack;
      n_count       = l_count;
      n_tail        = l_tail;
      n_head        = l_head;
      link_we       = 1'b0;
      link_wa       = grab_node;
      link_wd       = l_head;
      link_re       = 1'b0;
      link_ra       = free_top;
      word_we       = 1'b0;
      word_wa       = grab_node;
      word_wd       = req_ff.data_in[STORE_W-1:0];
      word_re       = 1'b0;
      word_ra       = l_head;
      pool_ctl.grab = 1'b0;
      pool_ctl.drop = 1'b0;

      case (state_ff)
         mlsq_pkg::S_IDLE: begin
            // Take the word and read the list entry and the free-chain link
            if (req_fire) begin
               req_in   = req_word;
               list_re  = 1'b1;
               link_re  = 1'b1;
               state_in = mlsq_pkg::S_LOOK;
            end
         end

         mlsq_pkg::S_LOOK: begin
            if (req_ff.cmd == mlsq_pkg::CMD_POP && slot_used && l_count != '0) begin
               // Fetch the head node's word and link
               link_re  = 1'b1;
               link_ra  = l_head;
               word_re  = 1'b1;
               state_in = mlsq_pkg::S_FETCH;
            end else if (out_free) begin
               rsp_load        = 1'b1;
               rsp_in.status   = mlsq_pkg::STAT_OK;
               rsp_in.data_out = '0;
               state_in        = mlsq_pkg::S_IDLE;
               case (req_ff.cmd)
                  mlsq_pkg::CMD_CREATE: begin
                     if (!id_ok) begin
                        rsp_in.status = mlsq_pkg::STAT_MISSING;
                     end else if (slot_used) begin
                        rsp_in.status = mlsq_pkg::STAT_EXISTS;
                     end else begin
                        // Open the slot as an empty list of the given kind
                        used_in[id_cur] = 1'b1;
                        list_we         = 1'b1;
                        n_stack         = req_ff.is_stack;
                        n_count         = '0;
                     end
                  end
                  mlsq_pkg::CMD_PUSH: begin
                     if (!slot_used) begin
                        rsp_in.status = mlsq_pkg::STAT_MISSING;
                     end else if (!pool_avail) begin
                        rsp_in.status = mlsq_pkg::STAT_FULL;
                     end else begin
                        // Link the new node at the head (stack) or tail (queue)
                        pool_ctl.grab = 1'b1;
                        word_we       = 1'b1;
                        list_we       = 1'b1;
                        n_count       = l_count + CNT_W'(1);
                        if (l_count == '0) begin
                           n_head = grab_node;
                           n_tail = grab_node;
                        end else if (l_stack) begin
                           link_we = 1'b1;
                           n_head  = grab_node;
                        end else begin
                           link_we = 1'b1;
                           link_wa = l_tail;
                           link_wd = grab_node;
                           n_tail  = grab_node;
                        end
                     end
                  end
                  mlsq_pkg::CMD_POP: begin
                     if (!slot_used) begin
                        rsp_in.status = mlsq_pkg::STAT_MISSING;
                     end else begin
                        rsp_in.status = mlsq_pkg::STAT_EMPTY;
                     end
                  end
                  default: begin
                     rsp_in.status = mlsq_pkg::STAT_OK;
                  end
               endcase
            end
         end

         mlsq_pkg::S_FETCH: begin
            // Unlink the head, return its word and push the node on the free chain
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_in.status   = mlsq_pkg::STAT_OK;
               rsp_in.data_out = mlsq_pkg::DATA_W'(word_rd);
               list_we         = 1'b1;
               n_head          = link_rd;
               n_count         = l_count - CNT_W'(1);
               link_we         = 1'b1;
               link_wa         = l_head;
               link_wd         = free_top;
               pool_ctl.drop   = 1'b1;
               state_in        = mlsq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mlsq_pkg::S_IDLE;
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlsq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- verif/tb_multi_list_stack_queue_manager.sv -----
// Self-checking testbench of the multi-list stack/queue manager: directed, random, backpressure and pool stress.
`timescale 1ns / 1ps

module tb_multi_list_stack_queue_manager;

   localparam int SLOT_COUNT = mlsq_pkg::LISTS_DEFAULT;
   localparam int NODE_COUNT = mlsq_pkg::NODES_DEFAULT;
   localparam int SETTLE     = 8;
   localparam int IDLE_LIMIT = 1000;
   localparam int LONG_HOLD  = 120;
   // Command code with no operation behind it
   localparam logic [mlsq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mlsq_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mlsq_pkg::rsp_type rsp_word;

   multi_list_stack_queue_manager u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow state of the list manager
   logic                        open_slot  [SLOT_COUNT];
   logic                        stack_slot [SLOT_COUNT];
   int                          top_node   [SLOT_COUNT];
   int                          last_node  [SLOT_COUNT];
   int                          depth_of   [SLOT_COUNT];
   logic [mlsq_pkg::DATA_W-1:0] node_data  [NODE_COUNT];
   int                          node_next  [NODE_COUNT];
   int                          untouched_base = 0;
   int                          recycle_head   = 0;
   int                          recycle_count  = 0;
   int                          open_total     = 0;

   mlsq_pkg::rsp_type pending_rsp[$];
   mlsq_pkg::rsp_type due_rsp;
   int                errors      = 0;
   int                idle_cycles = 0;
   int                hold_cycles = 0;
   int                rx_wait     = 0;
   int                rx_draw;
   bit                brisk       = 1'b0;

   initial begin
      foreach (open_slot[i]) begin
         open_slot[i]  = 1'b0;
         stack_slot[i] = 1'b0;
         depth_of[i]   = 0;
      end
   end

   // Apply one command to the shadow state and return the word it answers with
   function automatic mlsq_pkg::rsp_type run_list_op(mlsq_pkg::req_type w);
      mlsq_pkg::rsp_type r;
      int                id;
      int                n;
      r.status   = mlsq_pkg::STAT_OK;
      r.data_out = '0;
      id = int'(w.list_id);
      case (w.cmd)
         mlsq_pkg::CMD_CREATE: begin
            if (open_slot[id]) begin
               r.status = mlsq_pkg::STAT_EXISTS;
            end else begin
               open_slot[id]  = 1'b1;
               stack_slot[id] = w.is_stack;
               depth_of[id]   = 0;
               open_total++;
            end
         end
         mlsq_pkg::CMD_PUSH: begin
            if (!open_slot[id]) begin
               r.status = mlsq_pkg::STAT_MISSING;
            end else begin
               // Recycled nodes first, then never-used ones
               n = -1;
               if (recycle_count > 0) begin
                  n = recycle_head;
                  recycle_head = node_next[n];
                  recycle_count--;
               end else if (untouched_base < NODE_COUNT) begin
                  n = untouched_base;
                  untouched_base++;
               end
               if (n < 0) begin
                  r.status = mlsq_pkg::STAT_FULL;
               end else begin
                  node_data[n] = w.data_in;
                  node_next[n] = 0;
                  if (depth_of[id] == 0) begin
                     top_node[id]  = n;
                     last_node[id] = n;
                  end else if (stack_slot[id]) begin
                     node_next[n] = top_node[id];
                     top_node[id] = n;
                  end else begin
                     node_next[last_node[id]] = n;
                     last_node[id] = n;
                  end
                  depth_of[id]++;
               end
            end
         end
         mlsq_pkg::CMD_POP: begin
            if (!open_slot[id]) begin
               r.status = mlsq_pkg::STAT_MISSING;
            end else if (depth_of[id] == 0) begin
               r.status = mlsq_pkg::STAT_EMPTY;
            end else begin
               // Unlink the head and return it to the free chain
               n = top_node[id];
               r.data_out   = node_data[n];
               top_node[id] = node_next[n];
               depth_of[id]--;
               node_next[n]  = recycle_head;
               recycle_head  = n;
               recycle_count++;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Offer one command word, wait for acceptance, record the expected answer
   task automatic send_cmd(input logic [mlsq_pkg::CMD_W-1:0] code,
                           input logic [mlsq_pkg::ID_W-1:0] id,
                           input logic st, input logic [mlsq_pkg::DATA_W-1:0] data,
                           output mlsq_pkg::rsp_type due);
      mlsq_pkg::req_type w;
      int                gap;
      w.cmd      = mlsq_pkg::cmd_type'(code);
      w.list_id  = id;
      w.is_stack = st;
      w.data_in  = data;
      gap = brisk ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = run_list_op(w);
      pending_rsp.insert(pending_rsp.size(), due);
   endtask

   // Random command, mostly aimed at open slots
   task automatic random_cmd(input int push_pct, input int pop_pct,
                             output mlsq_pkg::rsp_type due);
      int                          r;
      logic [mlsq_pkg::CMD_W-1:0]  code;
      logic [mlsq_pkg::ID_W-1:0]   id;
      logic [mlsq_pkg::DATA_W-1:0] data;
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
         code = mlsq_pkg::CMD_PUSH;
      end else if (r < push_pct + pop_pct) begin
         code = mlsq_pkg::CMD_POP;
      end else begin
         code = ($urandom_range(0, 2) == 0) ? CMD_NOP : mlsq_pkg::CMD_CREATE;
      end
      if (open_total > 0 && $urandom_range(0, 99) < 85) begin
         do id = mlsq_pkg::ID_W'($urandom_range(0, SLOT_COUNT - 1)); while (!open_slot[id]);
      end else begin
         id = mlsq_pkg::ID_W'($urandom_range(0, SLOT_COUNT - 1));
      end
      case ($urandom_range(0, 9))
         0: data = '0;
         1: data = '1;
         default: data = $urandom;
      endcase
      send_cmd(code, id, 1'($urandom_range(0, 1)), data, due);
   endtask

   // Drop valid and hold until every answer is in, then let the block settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_directed();
      mlsq_pkg::rsp_type due;
      send_cmd(mlsq_pkg::CMD_POP,    4'd3,  1'b0, 32'h0,         due);
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd3,  1'b1, 32'h1234_5678, due);
      send_cmd(CMD_NOP,              4'd7,  1'b1, 32'hDEAD_BEEF, due);
      send_cmd(mlsq_pkg::CMD_CREATE, 4'd0,  1'b1, 32'h0,         due);
      send_cmd(mlsq_pkg::CMD_CREATE, 4'd0,  1'b0, 32'h0,         due);
      send_cmd(mlsq_pkg::CMD_CREATE, 4'd15, 1'b0, 32'hFFFF_FFFF, due);
      send_cmd(mlsq_pkg::CMD_POP,    4'd0,  1'b0, 32'h0,         due);
      // Stack order: last in, first out
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd0,  1'b0, 32'h0000_0000, due);
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd0,  1'b1, 32'hFFFF_FFFF, due);
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd0,  1'b0, 32'hA5A5_A5A5, due);
      repeat (3) send_cmd(mlsq_pkg::CMD_POP, 4'd0, 1'b0, 32'h0, due);
      send_cmd(mlsq_pkg::CMD_POP,    4'd0,  1'b1, 32'h0,         due);
      // Queue order: first in, first out
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd15, 1'b0, 32'h5A5A_5A5A, due);
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd15, 1'b1, 32'h0000_0000, due);
      send_cmd(mlsq_pkg::CMD_PUSH,   4'd15, 1'b0, 32'hFFFF_FFFF, due);
      repeat (3) send_cmd(mlsq_pkg::CMD_POP, 4'd15, 1'b0, 32'h0, due);
      send_cmd(mlsq_pkg::CMD_POP,    4'd15, 1'b0, 32'h0,         due);
      send_cmd(mlsq_pkg::CMD_CREATE, 4'd15, 1'b1, 32'h0,         due);
      send_cmd(CMD_NOP,              4'd15, 1'b1, 32'hFFFF_FFFF, due);
   endtask

   task automatic test_random();
      mlsq_pkg::rsp_type due;
      for (int i = 0; i < 80; i++) begin
         if (i % 40 == 0) brisk = ($urandom_range(0, 3) == 0);
         random_cmd(44, 40, due);
      end
      brisk = 1'b0;
   endtask

   // Receiver holds off long while the sender keeps offering words
   task automatic test_backpressure();
      mlsq_pkg::rsp_type due;
      @(negedge clock);
      hold_cycles = LONG_HOLD;
      @(posedge clock);
      brisk = 1'b1;
      repeat (24) random_cmd(44, 40, due);
      brisk = 1'b0;
   endtask

   // Exhaust the node pool, then drain it back down
   task automatic test_pool_full();
      mlsq_pkg::rsp_type due;
      int                full_seen;
      full_seen = 0;
      while (full_seen < 5) begin
         random_cmd(88, 6, due);
         if (due.status == mlsq_pkg::STAT_FULL) full_seen++;
      end
      while (untouched_base - recycle_count > 8) random_cmd(10, 84, due);
   endtask

   // Receiver: random stall per word, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait   <= 0;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (rx_wait > 0) begin
         rsp_stall <= 1'b1;
         rx_wait   <= rx_wait - 1;
      end else if (rsp_valid && !rsp_stall) begin
         rx_draw = brisk ? 0 : $urandom_range(0, 6);
         rsp_stall <= (rx_draw > 0);
         rx_wait   <= (rx_draw > 0) ? rx_draw - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted answer with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("answer word with nothing expected");
         end else begin
            due_rsp = pending_rsp.pop_front();
            if (rsp_word.status !== due_rsp.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_word.status, due_rsp.status));
            if (rsp_word.data_out !== due_rsp.data_out)
               report_mismatch($sformatf("data_out %h, expected %h",
                                         rsp_word.data_out, due_rsp.data_out));
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("multi_list_stack_queue_manager regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_quiet();
      test_random();
      wait_quiet();
      test_backpressure();
      wait_quiet();
      test_pool_full();
      wait_quiet();
      if (errors == 0) begin
         $display("multi_list_stack_queue_manager regression: pass");
      end else begin
         $display("multi_list_stack_queue_manager regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mlsq_pkg.sv
rtl/mlsq_ram.sv
rtl/mlsq_pool.sv
rtl/multi_list_stack_queue_manager.sv
verif/tb_multi_list_stack_queue_manager.sv
